FILE: hw/rtl/ipv4_policy_filter_top_defines.svh
// Assertion macros used by the policy filter RTL.
`ifndef IPV4_POLICY_FILTER_TOP_DEFINES_SVH
`define IPV4_POLICY_FILTER_TOP_DEFINES_SVH
// Same-cycle implication, reset masks the check.
`define IPF_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ipf check failed");
// Next-cycle implication, reset masks the check.
`define IPF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ipf check failed");
`endif

FILE: hw/rtl/ipf_pkg.sv
// Types, codes and constants of the IPv4 policy filter.
package ipf_pkg;
   localparam int RULES_PER_DIRECTION = 256;

   localparam logic [1:0] OP_CLASSIFY = 2'd0;
   localparam logic [1:0] OP_WRITE    = 2'd1;
   localparam logic [1:0] OP_DELETE   = 2'd2;

   localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
   localparam logic [7:0]  PROTO_TCP      = 8'd6;
   localparam logic [7:0]  PROTO_UDP      = 8'd17;

   localparam logic [2:0] LEVEL_DEFAULT = 3'd5;
   localparam logic [2:0] LEVEL_NONE    = 3'd6;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_FULL   = 2'd1;
   localparam logic [1:0] ST_ABSENT = 2'd2;

   localparam logic CSR_DEF_INGRESS = 1'b0;
   localparam logic CSR_DEF_EGRESS  = 1'b1;

   typedef struct packed {
      logic [31:0] src;
      logic [31:0] dst;
      logic [15:0] port;
      logic [7:0]  proto;
   } key_type;

   typedef struct packed {
      logic    valid;
      key_type key;
      logic    action;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);
endpackage

FILE: hw/rtl/ipf_if.sv
// Request and response channel interfaces of the policy filter.
interface ipf_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  operation;
   logic        direction;
   logic [15:0] frame_length;
   logic [15:0] ether_type;
   logic [31:0] source_address;
   logic [31:0] destination_address;
   logic [7:0]  ip_protocol;
   logic [15:0] dest_port;
   logic        rule_action;
   modport source (output valid, operation, direction, frame_length, ether_type,
      source_address, destination_address, ip_protocol, dest_port, rule_action,
      input ready);
   modport sink (input valid, operation, direction, frame_length, ether_type,
      source_address, destination_address, ip_protocol, dest_port, rule_action,
      output ready);
endinterface

interface ipf_rsp_if;
   logic        valid;
   logic        ready;
   logic        verdict;
   logic [2:0]  match_level;
   logic [63:0] counter_value;
   logic [1:0]  status;
   modport source (output valid, verdict, match_level, counter_value, status,
      input ready);
   modport sink (input valid, verdict, match_level, counter_value, status,
      output ready);
endinterface

FILE: hw/rtl/ipf_ram.sv
// Generic single-port RAM with registered read data.
module ipf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;
endmodule

FILE: hw/rtl/ipv4_policy_filter_top.sv
// IPv4 five-tuple policy filter: rule store, scan sequencer and counters.
// Usage:
//   req_ch carries one transaction per item: classify (0), rule write (1),
//   rule delete (2). rsp_ch returns exactly one transaction per request.
//   csr_we/csr_index/csr_wdata set the ingress (0) and egress (1) defaults;
//   write them only while the block is idle.
// Sweep:
//   A classify, write or delete sweeps the direction's bank of the rule RAM
//   once, one entry per cycle, and checks each entry against all five probe
//   keys at once. Truncated or non-IPv4 frames and unused opcodes skip the
//   sweep. The single RAM read port sets that rate; a new request is accepted
//   only once the block is back in idle.
// Reset:
//   Synchronous active-high reset clears counters and defaults, then a clear
//   pass writes every RAM row of both banks invalid; req_ch.ready stays low
//   meanwhile. CSR writes are taken.
// Stall:
//   The response register holds while rsp_ch.ready is low; a new request is
//   still accepted, and its result waits until the register frees.
`include "ipv4_policy_filter_top_defines.svh"
module ipv4_policy_filter_top #(
   parameter int RULES_PER_DIRECTION = ipf_pkg::RULES_PER_DIRECTION
) (
   input  logic          clock,
   input  logic          reset,
   ipf_req_if.sink       req_ch,
   ipf_rsp_if.source     rsp_ch,
   input  logic          csr_we,
   input  logic          csr_index,
   input  logic          csr_wdata
);
   localparam int IDX_W  = (RULES_PER_DIRECTION > 1) ? $clog2(RULES_PER_DIRECTION) : 1;
   localparam int ADDR_W = IDX_W + 1;
   localparam int DEPTH  = 2 ** ADDR_W;
   localparam int CNT_W  = $clog2(RULES_PER_DIRECTION + 1);
   localparam logic [CNT_W-1:0] RULES_C = CNT_W'(RULES_PER_DIRECTION);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RULES_PER_DIRECTION - 1);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_CLEAR  = 2'd1;
   localparam logic [1:0] S_SCAN   = 2'd2;
   localparam logic [1:0] S_FINISH = 2'd3;

   logic [1:0] state_ff, state_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic [CNT_W-1:0] iss_ff, iss_in;
   logic rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0] rd_idx_ff, rd_idx_in;

   logic [1:0] op_ff, op_in;
   logic dir_ff, dir_in;
   logic ract_ff, ract_in;
   ipf_pkg::key_type key_ff, key_in;

   logic [2:0] best_ff, best_in;
   logic best_act_ff, best_act_in;
   logic found_ff, found_in;
   logic [IDX_W-1:0] found_idx_ff, found_idx_in;
   logic free_ff, free_in;
   logic [IDX_W-1:0] free_idx_ff, free_idx_in;

   logic def_ff [2];
   logic [63:0] stats_ff [4];

   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_verdict_ff, rsp_verdict_in;
   logic [2:0] rsp_level_ff, rsp_level_in;
   logic [63:0] rsp_count_ff, rsp_count_in;
   logic [1:0] rsp_status_ff, rsp_status_in;

   logic ram_we;
   logic [ADDR_W-1:0] ram_addr;
   ipf_pkg::entry_type ram_wdata, ram_rdata;
   logic [ipf_pkg::ENTRY_W-1:0] ram_rdata_raw;

   logic req_fire, slot_free, finish_fire, trunc, tcp_udp;
   logic stats_we;
   logic [1:0] stats_sel;
   logic [63:0] stats_new;
   ipf_pkg::key_type probe [5];

   ipf_ram #(.WIDTH(ipf_pkg::ENTRY_W), .DEPTH(DEPTH)) u_rules (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata_raw)
   );
   assign ram_rdata = ipf_pkg::entry_type'(ram_rdata_raw);

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_fire    = req_ch.valid && req_ch.ready;
   assign slot_free   = !rsp_valid_ff || rsp_ch.ready;
   assign finish_fire = (state_ff == S_FINISH) && slot_free;

   assign tcp_udp = (req_ch.ip_protocol == ipf_pkg::PROTO_TCP) ||
                    (req_ch.ip_protocol == ipf_pkg::PROTO_UDP);
   assign trunc = (req_ch.frame_length < 16'd14) ||
                  (req_ch.ether_type != ipf_pkg::ETHERTYPE_IPV4) ||
                  (req_ch.frame_length < 16'd34) ||
                  ((req_ch.ip_protocol == ipf_pkg::PROTO_TCP) &&
                   (req_ch.frame_length < 16'd54)) ||
                  ((req_ch.ip_protocol == ipf_pkg::PROTO_UDP) &&
                   (req_ch.frame_length < 16'd42));

   // Probe keys, each more wildcarded than the one before.
   always_comb begin
      probe[0] = key_ff;
      probe[1] = probe[0];
      probe[1].src = '0;
      probe[2] = probe[1];
      probe[2].dst = '0;
      probe[3] = probe[2];
      probe[3].port = '0;
      probe[4] = probe[3];
      probe[4].proto = '0;
   end

   always_comb begin
      ram_we    = 1'b0;
      ram_addr  = {dir_ff, iss_ff[IDX_W-1:0]};
      ram_wdata = '0;
      unique case (state_ff)
         S_CLEAR: begin
            ram_we   = 1'b1;
            ram_addr = clr_ff;
         end
         S_FINISH: begin
            ram_wdata.key = key_ff;
            if (op_ff == ipf_pkg::OP_WRITE) begin
               ram_wdata.valid  = 1'b1;
               ram_wdata.action = ract_ff;
               ram_we   = finish_fire && (found_ff || free_ff);
               ram_addr = {dir_ff, found_ff ? found_idx_ff : free_idx_ff};
            end else if (op_ff == ipf_pkg::OP_DELETE) begin
               ram_we   = finish_fire && found_ff;
               ram_addr = {dir_ff, found_idx_ff};
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      iss_in        = iss_ff;
      rd_vld_in     = 1'b0;
      rd_idx_in     = iss_ff[IDX_W-1:0];
      op_in         = op_ff;
      dir_in        = dir_ff;
      ract_in       = ract_ff;
      key_in        = key_ff;
      best_in       = best_ff;
      best_act_in   = best_act_ff;
      found_in      = found_ff;
      found_idx_in  = found_idx_ff;
      free_in       = free_ff;
      free_idx_in   = free_idx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_verdict_in = rsp_verdict_ff;
      rsp_level_in  = rsp_level_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_status_in = rsp_status_ff;
      stats_we      = 1'b0;
      stats_sel     = {dir_ff, ~best_act_ff};
      stats_new     = 64'd0;
      unique case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + ADDR_W'(1);
            if (clr_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               op_in   = req_ch.operation;
               dir_in  = req_ch.direction;
               ract_in = req_ch.rule_action;
               key_in.src   = req_ch.source_address;
               key_in.dst   = req_ch.destination_address;
               key_in.proto = req_ch.ip_protocol;
               key_in.port  = (req_ch.operation != ipf_pkg::OP_CLASSIFY || tcp_udp) ?
                              req_ch.dest_port : 16'd0;
               best_in  = ipf_pkg::LEVEL_DEFAULT;
               found_in = 1'b0;
               free_in  = 1'b0;
               iss_in   = '0;
               if ((req_ch.operation == ipf_pkg::OP_CLASSIFY && !trunc) ||
                   req_ch.operation == ipf_pkg::OP_WRITE ||
                   req_ch.operation == ipf_pkg::OP_DELETE) begin
                  state_in = S_SCAN;
               end else begin
                  // Not classified: report with no sweep.
                  best_in  = ipf_pkg::LEVEL_NONE;
                  state_in = S_FINISH;
               end
            end
         end
         S_SCAN: begin
            if (iss_ff < RULES_C) begin
               iss_in    = iss_ff + CNT_W'(1);
               rd_vld_in = 1'b1;
            end
            if (rd_vld_ff) begin
               // Descend so that the most specific hit wins.
               for (int lv = 4; lv >= 0; lv--) begin
                  if (ram_rdata.valid && ram_rdata.key == probe[lv] &&
                      3'(lv) < best_in) begin
                     best_in     = 3'(lv);
                     best_act_in = ram_rdata.action;
                  end
               end
               if (ram_rdata.valid && ram_rdata.key == probe[0]) begin
                  found_in     = 1'b1;
                  found_idx_in = rd_idx_ff;
               end
               if (!ram_rdata.valid && !free_ff) begin
                  free_in     = 1'b1;
                  free_idx_in = rd_idx_ff;
               end
               if (rd_idx_ff == LAST_IDX) begin
                  state_in = S_FINISH;
               end
            end
         end
         S_FINISH: begin
            if (slot_free) begin
               state_in       = S_IDLE;
               rsp_valid_in   = 1'b1;
               rsp_verdict_in = 1'b0;
               rsp_level_in   = ipf_pkg::LEVEL_NONE;
               rsp_count_in   = 64'd0;
               rsp_status_in  = ipf_pkg::ST_OK;
               if (op_ff == ipf_pkg::OP_WRITE) begin
                  if (!found_ff && !free_ff) begin
                     rsp_status_in = ipf_pkg::ST_FULL;
                  end
               end else if (op_ff == ipf_pkg::OP_DELETE) begin
                  if (!found_ff) begin
                     rsp_status_in = ipf_pkg::ST_ABSENT;
                  end
               end else if (best_ff != ipf_pkg::LEVEL_NONE) begin
                  priority if (best_ff == ipf_pkg::LEVEL_DEFAULT) begin
                     stats_sel = {dir_ff, ~def_ff[dir_ff]};
                  end else begin
                     stats_sel = {dir_ff, ~best_act_ff};
                  end
                  stats_we       = 1'b1;
                  stats_new      = stats_ff[stats_sel] + 64'd1;
                  rsp_verdict_in = stats_sel[0];
                  rsp_level_in   = best_ff;
                  rsp_count_in   = stats_new;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         def_ff[0]    <= 1'b0;
         def_ff[1]    <= 1'b0;
         for (int i = 0; i < 4; i++) begin
            stats_ff[i] <= 64'd0;
         end
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               ipf_pkg::CSR_DEF_INGRESS: def_ff[0] <= csr_wdata;
               ipf_pkg::CSR_DEF_EGRESS:  def_ff[1] <= csr_wdata;
            endcase
         end
         if (stats_we) begin
            stats_ff[stats_sel] <= stats_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      iss_ff         <= iss_in;
      rd_idx_ff      <= rd_idx_in;
      op_ff          <= op_in;
      dir_ff         <= dir_in;
      ract_ff        <= ract_in;
      key_ff         <= key_in;
      best_ff        <= best_in;
      best_act_ff    <= best_act_in;
      found_ff       <= found_in;
      found_idx_ff   <= found_idx_in;
      free_ff        <= free_in;
      free_idx_ff    <= free_idx_in;
      rsp_verdict_ff <= rsp_verdict_in;
      rsp_level_ff   <= rsp_level_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_status_ff  <= rsp_status_in;
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.verdict       = rsp_verdict_ff;
   assign rsp_ch.match_level   = rsp_level_ff;
   assign rsp_ch.counter_value = rsp_count_ff;
   assign rsp_ch.status        = rsp_status_ff;

   `IPF_ASSERT_NEXT(a_accept_leaves_idle, clock, reset, req_fire, state_ff != S_IDLE)
   `IPF_ASSERT_NOW(a_ram_write_state, clock, reset, ram_we,
      state_ff == S_CLEAR || state_ff == S_FINISH)
   `IPF_ASSERT_NEXT(a_finish_emits, clock, reset, finish_fire, rsp_valid_ff)
endmodule
